// File: src/ping_pong_byte_buffer_assert.svh
// Assertion macros used by the ping-pong byte buffer RTL
`ifndef PING_PONG_BYTE_BUFFER_ASSERT_SVH
`define PING_PONG_BYTE_BUFFER_ASSERT_SVH

// Check prop on every rising edge of clk_i outside reset
`define PPBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that expr never holds on a rising edge of clk_i outside reset
`define PPBB_ASSERT_NEVER(lbl, expr, msg) \
  `PPBB_ASSERT(lbl, !(expr), msg)

`endif

// File: src/ppbb_pkg.sv
// Package with constants and types of the ping-pong byte buffer
`default_nettype none
package ppbb_pkg;

  localparam int DATA_WIDTH      = 8;
  localparam int CFG_WIDTH       = 15;
  localparam int BANK_SIZE_RESET = 16384;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic we;
    logic re;
  } access_t;

endpackage
`default_nettype wire

// File: src/ppbb_if.sv
// Handshake interfaces for the command and result channels
`default_nettype none
interface ppbb_in_if;
  import ppbb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [DATA_WIDTH-1:0] wdata;

  modport source (output valid, output cmd, output wdata, input ready);
  modport sink (input valid, input cmd, input wdata, output ready);
endinterface

interface ppbb_out_if;
  import ppbb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  rvalid;
  logic                  accepted;

  modport source (output valid, output rdata, output rvalid, output accepted, input ready);
  modport sink (input valid, input rdata, input rvalid, input accepted, output ready);
endinterface
`default_nettype wire

// File: src/ping_pong_byte_buffer.sv
// Top level of the ping-pong byte buffer: bank memory and result register
//
//  channel  dir  handshake     word
//  in_i     in   valid/ready   cmd, wdata
//  out_o    out  valid/ready   rdata, rvalid, accepted
//  cfg      in   cfg_we_i      cfg_wdata_i (bank_size)
//
// One word per cycle while results are taken; a result appears in the cycle after
// its command is taken, set by the single-port bank memory's registered read.
// Reset clears bank select, positions and fill counts; bank contents stay unknown.
// A result not taken holds in the output register and stops new commands.
`default_nettype none
module ping_pong_byte_buffer #(
  parameter int BANK_DEPTH = 16384
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ppbb_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  ppbb_in_if.sink                             in_i,
  ppbb_out_if.source                          out_o
);
  import ppbb_pkg::*;

  localparam int AW = $clog2(BANK_DEPTH) + 1;

  logic [DATA_WIDTH-1:0] mem [2**AW];
  logic [DATA_WIDTH-1:0] mem_rd_q;
  logic                  res_valid_q;
  logic                  rvalid_q;
  logic                  accepted_q;
  logic                  go;
  access_t               access;
  logic [AW-1:0]         addr;

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign go         = in_i.valid && in_i.ready;

  ppbb_ctrl #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .go_i        (go),
    .cmd_i       (in_i.cmd),
    .access_o    (access),
    .addr_o      (addr)
  );

  always_ff @(posedge clk_i) begin
    if (access.we) begin
      mem[addr] <= in_i.wdata;
    end
    if (access.re) begin
      mem_rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      rvalid_q   <= access.re;
      accepted_q <= access.we;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (go) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign out_o.valid    = res_valid_q;
  assign out_o.rvalid   = rvalid_q;
  assign out_o.accepted = accepted_q;
  assign out_o.rdata    = rvalid_q ? mem_rd_q : '0;

endmodule
`default_nettype wire

// File: src/ppbb_ctrl.sv
// Bank select, position and fill counters, and size register of the buffer
`default_nettype none
module ppbb_ctrl #(
  parameter int BANK_DEPTH = 16384
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ppbb_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  input  wire logic                          go_i,
  input  wire logic                          cmd_i,
  output ppbb_pkg::access_t                  access_o,
  output logic [$clog2(BANK_DEPTH):0]        addr_o
);
  import ppbb_pkg::*;

  localparam int PW = $clog2(BANK_DEPTH);
  localparam int SW = $clog2(BANK_DEPTH + 1);
  localparam int CW = (SW > CFG_WIDTH) ? SW : CFG_WIDTH;
  localparam int SIZE_RST_INT = (BANK_DEPTH < BANK_SIZE_RESET) ? BANK_DEPTH : BANK_SIZE_RESET;
  localparam logic [SW-1:0] SIZE_RST = SW'(SIZE_RST_INT);

  logic [SW-1:0] size_q;
  logic          rb_q, rb_d;
  logic [PW-1:0] rpos_q, rpos_d;
  logic [PW-1:0] wpos_q, wpos_d;
  logic [SW-1:0] rfill_q, rfill_d;
  logic [SW-1:0] wfill_q, wfill_d;

  function automatic logic [SW-1:0] clamp_size(input logic [CFG_WIDTH-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    if (ext == '0) begin
      return SW'(1);
    end else if (ext > CW'(BANK_DEPTH)) begin
      return SW'(BANK_DEPTH);
    end
    return SW'(ext);
  endfunction

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [SW-1:0] s);
    logic [PW:0] n;
    n = (PW+1)'(p) + (PW+1)'(1);
    return (n >= (PW+1)'(s)) ? '0 : n[PW-1:0];
  endfunction

  always_comb begin
    rb_d     = rb_q;
    rpos_d   = rpos_q;
    wpos_d   = wpos_q;
    rfill_d  = rfill_q;
    wfill_d  = wfill_q;
    access_o = '0;
    addr_o   = '0;
    if (go_i) begin
      if (cmd_i == CMD_WRITE) begin
        if (wfill_q < size_q) begin
          access_o.we = 1'b1;
          addr_o      = {~rb_q, wpos_q};
          wpos_d      = advance(wpos_q, size_q);
          wfill_d     = wfill_q + SW'(1);
        end
      end else begin
        // swap first when the read bank is empty
        if (rfill_d == '0) begin
          rb_d    = ~rb_d;
          rpos_d  = '0;
          rfill_d = wfill_d;
          wpos_d  = '0;
          wfill_d = '0;
        end
        if (rfill_d != '0) begin
          access_o.re = 1'b1;
          addr_o      = {rb_d, rpos_d};
          rpos_d      = advance(rpos_d, size_q);
          rfill_d     = rfill_d - SW'(1);
          // swap as soon as the read bank runs dry
          if (rfill_d == '0) begin
            rb_d    = ~rb_d;
            rpos_d  = '0;
            rfill_d = wfill_d;
            wpos_d  = '0;
            wfill_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RST;
      rb_q    <= 1'b0;
      rpos_q  <= '0;
      wpos_q  <= '0;
      rfill_q <= '0;
      wfill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= clamp_size(cfg_wdata_i);
      end
      rb_q    <= rb_d;
      rpos_q  <= rpos_d;
      wpos_q  <= wpos_d;
      rfill_q <= rfill_d;
      wfill_q <= wfill_d;
    end
  end

  `include "ping_pong_byte_buffer_assert.svh"

  `PPBB_ASSERT_NEVER(a_we_re_excl, access_o.we && access_o.re, "write and read in one cycle")
  `PPBB_ASSERT(a_fill_bound, (rfill_q <= SW'(BANK_DEPTH)) && (wfill_q <= SW'(BANK_DEPTH)), "fill count beyond bank depth")
  `PPBB_ASSERT(a_refused_hold, (go_i && cmd_i == CMD_WRITE && !access_o.we) |=> ($stable(wfill_q) && $stable(wpos_q)), "refused write changed write side")
  `PPBB_ASSERT(a_read_leaves_data, (go_i && cmd_i == CMD_READ) |=> (rfill_q != '0 || wfill_q == '0), "read left empty read bank with data pending")

endmodule
`default_nettype wire
